// ===== rtl/u8dec_pkg.sv =====
// types, constants and the windows-1252 table shared by the decoder modules
`timescale 1ns / 1ps

package u8dec_pkg;

  localparam int unsigned CpW       = 21;
  localparam int unsigned MaxRes    = 4;
  localparam int unsigned CntW      = $clog2(MaxRes + 1);
  localparam int unsigned IdxW      = $clog2(MaxRes);
  localparam int unsigned JobQDepth = 2;

  localparam logic [CpW-1:0] ReplReset = 21'h00FFFD;
  localparam logic [CpW-1:0] SurrLo    = 21'h00D800;
  localparam logic [CpW-1:0] SurrHi    = 21'h00DFFF;
  localparam logic [CpW-1:0] CpMax     = 21'h10FFFF;

  localparam logic [15:0] Cp1252Hi [32] = '{
    16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D, 16'h017D, 16'h008F,
    16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
    16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h009D, 16'h017E, 16'h0178
  };

  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           fb;
    logic           rep;
  } entry_t;

  // one input beat worth of results
  typedef struct packed {
    logic [CntW-1:0]          cnt;
    entry_t [MaxRes-1:0]      ent;
  } job_t;

  function automatic logic [CpW-1:0] map_1252(input logic [7:0] b);
    logic [CpW-1:0] r;
    if (b[7:5] == 3'b100) begin
      r = {5'b0, Cp1252Hi[b[4:0]]};
    end else begin
      r = {13'b0, b};
    end
    return r;
  endfunction

endpackage

// ===== rtl/u8dec_front.sv =====
// front end: sequence tracking, decode and per-beat job build
`timescale 1ns / 1ps

module u8dec_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        byte_in_i,
  input  logic              end_of_text_i,
  input  logic              cfg_we_i,
  input  logic [u8dec_pkg::CpW-1:0] cfg_wdata_i,
  output logic              job_valid_o,
  output u8dec_pkg::job_t   job_o
);

  logic [u8dec_pkg::CpW-1:0] repl_q;
  logic [7:0]                lead_q, lead_d;
  logic [1:0]                need_q, need_d;
  logic [1:0]                held_q, held_d;
  logic [7:0]                h_q [2];
  logic [7:0]                h_d [2];

  logic                       cont, pend, is_lead, complete;
  logic [1:0]                 held_inc, need_new;
  logic [u8dec_pkg::CntW-1:0] base;
  logic                       emit_b, use_dec, dec_rep;
  logic [u8dec_pkg::CpW-1:0]  dec_v;
  logic [7:0]                 seq [u8dec_pkg::MaxRes];
  logic [7:0]                 src;
  u8dec_pkg::job_t            job;

  assign cont     = (byte_in_i[7:6] == 2'b10);
  assign pend     = (need_q != 2'd0);
  assign is_lead  = byte_in_i inside {[8'hC0:8'hF7]};
  assign held_inc = held_q + 2'd1;
  assign complete = (held_inc == need_q);

  always_comb begin
    if (byte_in_i <= 8'hDF) begin
      need_new = 2'd1;
    end else if (byte_in_i <= 8'hEF) begin
      need_new = 2'd2;
    end else begin
      need_new = 2'd3;
    end
  end

  // decode of a finished sequence
  always_comb begin
    case (need_q)
      2'd1:    dec_v = {10'b0, lead_q[4:0], byte_in_i[5:0]};
      2'd2:    dec_v = {5'b0, lead_q[3:0], h_q[0][5:0], byte_in_i[5:0]};
      2'd3:    dec_v = {lead_q[2:0], h_q[0][5:0], h_q[1][5:0], byte_in_i[5:0]};
      default: dec_v = '0;
    endcase
    dec_rep = ((dec_v >= u8dec_pkg::SurrLo) && (dec_v <= u8dec_pkg::SurrHi))
              || (dec_v > u8dec_pkg::CpMax);
  end

  always_comb begin
    lead_d  = lead_q;
    need_d  = need_q;
    held_d  = held_q;
    h_d     = h_q;
    base    = '0;
    emit_b  = 1'b0;
    use_dec = 1'b0;
    if (pend && cont) begin
      if (complete) begin
        use_dec = 1'b1;
        need_d  = 2'd0;
        held_d  = 2'd0;
      end else begin
        h_d[held_q[0]] = byte_in_i;
        held_d         = held_inc;
        if (end_of_text_i) begin
          base   = u8dec_pkg::CntW'(held_q) + u8dec_pkg::CntW'(1);
          emit_b = 1'b1;
          need_d = 2'd0;
          held_d = 2'd0;
        end
      end
    end else begin
      base   = pend ? (u8dec_pkg::CntW'(held_q) + u8dec_pkg::CntW'(1)) : '0;
      emit_b = !is_lead || end_of_text_i;
      need_d = 2'd0;
      held_d = 2'd0;
      if (is_lead && !end_of_text_i) begin
        lead_d = byte_in_i;
        need_d = need_new;
      end
    end
  end

  // flushed bytes first, then the incoming byte
  assign seq[0] = lead_q;
  assign seq[1] = h_q[0];
  assign seq[2] = h_q[1];
  assign seq[3] = lead_q;

  always_comb begin
    src = '0;
    job = '0;
    job.cnt = base + u8dec_pkg::CntW'(emit_b);
    for (int i = 0; i < u8dec_pkg::MaxRes; i++) begin
      src = (u8dec_pkg::CntW'(i) < base) ? seq[i] : byte_in_i;
      job.ent[i].cp  = u8dec_pkg::map_1252(src);
      job.ent[i].fb  = (u8dec_pkg::CntW'(i) < base) || byte_in_i[7];
      job.ent[i].rep = 1'b0;
    end
    if (use_dec) begin
      job.cnt        = u8dec_pkg::CntW'(1);
      job.ent[0].cp  = dec_rep ? repl_q : dec_v;
      job.ent[0].fb  = 1'b0;
      job.ent[0].rep = dec_rep;
    end
  end

  assign job_valid_o = accept_i && (job.cnt != '0);
  assign job_o       = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repl_q <= u8dec_pkg::ReplReset;
      lead_q <= '0;
      need_q <= '0;
      held_q <= '0;
    end else begin
      if (cfg_we_i) begin
        repl_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        lead_q <= lead_d;
        need_q <= need_d;
        held_q <= held_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      h_q <= h_d;
    end
  end

  a_held_below_need: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (need_q != 2'd0) |-> (held_q < need_q))
    else $error("held count reached needed count");

  a_idle_no_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (need_q == 2'd0) |-> (held_q == 2'd0))
    else $error("held bytes with no sequence pending");

endmodule

// ===== rtl/u8dec_jobq.sv =====
// short job queue between front and back
`timescale 1ns / 1ps

module u8dec_jobq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  u8dec_pkg::job_t wdata_i,
  input  logic            rd_i,
  output u8dec_pkg::job_t rdata_o,
  output logic            full_o,
  output logic            empty_o
);

  localparam int unsigned PtrW = $clog2(u8dec_pkg::JobQDepth);
  localparam int unsigned CntW = $clog2(u8dec_pkg::JobQDepth + 1);

  u8dec_pkg::job_t mem_q [u8dec_pkg::JobQDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            wr, rd;

  assign full_o  = (cnt_q == CntW'(u8dec_pkg::JobQDepth));
  assign empty_o = (cnt_q == '0);
  assign wr      = wr_i && !full_o;
  assign rd      = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr) begin
        wptr_q <= (wptr_q == PtrW'(u8dec_pkg::JobQDepth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (rd) begin
        rptr_q <= (rptr_q == PtrW'(u8dec_pkg::JobQDepth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (wr && !rd) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (rd && !wr) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  a_no_write_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> !full_o)
    else $error("job written into full queue");

endmodule

// ===== rtl/u8dec_back.sv =====
// back end: walks each job and feeds the result register one beat a cycle while that register is free or being popped
`timescale 1ns / 1ps

module u8dec_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      job_valid_i,
  input  u8dec_pkg::job_t           job_i,
  output logic                      job_pop_o,
  input  logic                      pop,
  output logic                      empty,
  output logic [u8dec_pkg::CpW-1:0] code_point_o,
  output logic                      from_fallback_o,
  output logic                      replaced_o,
  output logic                      last_of_run_o
);

  logic [u8dec_pkg::IdxW-1:0] idx_q, idx_d;
  logic                       oval_q, oval_d;
  u8dec_pkg::entry_t          ent_q;
  logic                       last_q;
  logic                       load, last;

  assign load = job_valid_i && (!oval_q || pop);
  assign last = (u8dec_pkg::CntW'(idx_q) == (job_i.cnt - u8dec_pkg::CntW'(1)));
  assign job_pop_o = load && last;

  always_comb begin
    idx_d  = idx_q;
    oval_d = oval_q;
    if (load) begin
      oval_d = 1'b1;
      idx_d  = last ? '0 : idx_q + u8dec_pkg::IdxW'(1);
    end else if (pop) begin
      oval_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      oval_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      oval_q <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ent_q  <= job_i.ent[idx_q];
      last_q <= last;
    end
  end

  assign empty           = !oval_q;
  assign code_point_o    = ent_q.cp;
  assign from_fallback_o = ent_q.fb;
  assign replaced_o      = ent_q.rep;
  assign last_of_run_o   = last_q;

  a_idx_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i |-> (u8dec_pkg::CntW'(idx_q) < job_i.cnt))
    else $error("result index beyond job length");

  a_job_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i |-> ((job_i.cnt != '0) && (job_i.cnt <= u8dec_pkg::CntW'(u8dec_pkg::MaxRes))))
    else $error("job with bad result count");

  a_idx_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |=> (idx_q == '0))
    else $error("index not rewound after job");

endmodule

// ===== rtl/utf8_decoder_win1252_fallback.sv =====
// utf-8 decoder with windows-1252 fallback, top level
// a beat's results go through the job queue into the result register
// throughput: one byte a cycle while the job queue is not full;
// the two-entry job queue lets the front keep taking bytes while results drain
// reset: asynchronous, clears sequence state, queue and result register;
// replacement code point returns to 0xfffd
`timescale 1ns / 1ps

module utf8_decoder_win1252_fallback (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [7:0]                byte_in_i,
  input  logic                      end_of_text_i,
  output logic                      empty,
  input  logic                      pop,
  output logic [u8dec_pkg::CpW-1:0] code_point_o,
  output logic                      from_fallback_o,
  output logic                      replaced_o,
  output logic                      last_of_run_o,
  input  logic                      cfg_we_i,
  input  logic [u8dec_pkg::CpW-1:0] cfg_wdata_i
);

  logic            accept;
  logic            job_wr, job_rd, q_full, q_empty;
  u8dec_pkg::job_t job_w, job_r;

  assign full   = q_full;
  assign accept = push && !q_full;

  u8dec_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .byte_in_i     (byte_in_i),
    .end_of_text_i (end_of_text_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .job_valid_o   (job_wr),
    .job_o         (job_w)
  );

  u8dec_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (job_wr),
    .wdata_i (job_w),
    .rd_i    (job_rd),
    .rdata_o (job_r),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  u8dec_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (!q_empty),
    .job_i           (job_r),
    .job_pop_o       (job_rd),
    .pop             (pop),
    .empty           (empty),
    .code_point_o    (code_point_o),
    .from_fallback_o (from_fallback_o),
    .replaced_o      (replaced_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule

// ===== bench/tb.sv =====
// self-checking testbench for the utf-8 decoder with windows-1252 fallback
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CpW        = u8dec_pkg::CpW;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 12;

  typedef struct packed {
    logic [7:0] data;
    logic       eot;
  } text_beat_t;

  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           fb;
    logic           rep;
    logic           last;
  } cp_beat_t;

  logic           clk_i         = 1'b0;
  logic           rst_ni        = 1'b0;
  logic           push          = 1'b0;
  logic           full;
  logic [7:0]     byte_in_i     = 8'h00;
  logic           end_of_text_i = 1'b0;
  logic           empty;
  logic           pop           = 1'b0;
  logic [CpW-1:0] code_point_o;
  logic           from_fallback_o;
  logic           replaced_o;
  logic           last_of_run_o;
  logic           cfg_we_i      = 1'b0;
  logic [CpW-1:0] cfg_wdata_i   = '0;

  utf8_decoder_win1252_fallback uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .byte_in_i      (byte_in_i),
    .end_of_text_i  (end_of_text_i),
    .empty          (empty),
    .pop            (pop),
    .code_point_o   (code_point_o),
    .from_fallback_o(from_fallback_o),
    .replaced_o     (replaced_o),
    .last_of_run_o  (last_of_run_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // decoder state as the bench sees it
  logic [CpW-1:0] repl_cp = 21'h00FFFD;
  logic [7:0]     seq_lead = 8'h00;
  logic [1:0]     seq_need = 2'd0;
  logic [1:0]     seq_held = 2'd0;
  logic [7:0]     seq_bytes [3];

  logic [CpW-1:0] step_cp  [4];
  logic           step_fb  [4];
  logic           step_rep [4];
  int             step_n;

  text_beat_t text_q [$];
  cp_beat_t   cp_expected_q [$];
  text_beat_t beat_now;
  cp_beat_t   cp_want;
  cp_beat_t   cp_got;

  int mismatches     = 0;
  int cycle_count    = 0;
  int beats_accepted = 0;
  int burst_left     = 0;
  int gap_left       = 0;
  int hold_left      = 0;
  int next_hold_at   = 40;
  int mode_left      = 0;
  int stall_mode     = 0;

  function automatic logic [CpW-1:0] win1252(input logic [7:0] b);
    logic [15:0] u;
    case (b)
      8'h80: u = 16'h20AC;  8'h82: u = 16'h201A;  8'h83: u = 16'h0192;
      8'h84: u = 16'h201E;  8'h85: u = 16'h2026;  8'h86: u = 16'h2020;
      8'h87: u = 16'h2021;  8'h88: u = 16'h02C6;  8'h89: u = 16'h2030;
      8'h8A: u = 16'h0160;  8'h8B: u = 16'h2039;  8'h8C: u = 16'h0152;
      8'h8E: u = 16'h017D;  8'h91: u = 16'h2018;  8'h92: u = 16'h2019;
      8'h93: u = 16'h201C;  8'h94: u = 16'h201D;  8'h95: u = 16'h2022;
      8'h96: u = 16'h2013;  8'h97: u = 16'h2014;  8'h98: u = 16'h02DC;
      8'h99: u = 16'h2122;  8'h9A: u = 16'h0161;  8'h9B: u = 16'h203A;
      8'h9C: u = 16'h0153;  8'h9E: u = 16'h017E;  8'h9F: u = 16'h0178;
      default: u = {8'h00, b};
    endcase
    return {5'b0, u};
  endfunction

  task automatic emit(input logic [CpW-1:0] cp, input logic fb, input logic rep);
    step_cp[step_n]  = cp;
    step_fb[step_n]  = fb;
    step_rep[step_n] = rep;
    step_n++;
  endtask

  task automatic flush_seq;
    int i;
    if (seq_need != 2'd0) begin
      emit(win1252(seq_lead), 1'b1, 1'b0);
      for (i = 0; i < seq_held; i++) emit(win1252(seq_bytes[i]), 1'b1, 1'b0);
      seq_need = 2'd0;
      seq_held = 2'd0;
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eot);
    logic [31:0] v;
    int          i;
    cp_beat_t    cp_new;
    step_n = 0;
    if (seq_need != 2'd0 && b[7:6] == 2'b10) begin
      seq_bytes[seq_held] = b;
      seq_held = seq_held + 2'd1;
      if (seq_held >= seq_need) begin
        case (seq_need)
          2'd1: v = {27'b0, seq_lead[4:0]};
          2'd2: v = {28'b0, seq_lead[3:0]};
          default: v = {29'b0, seq_lead[2:0]};
        endcase
        for (i = 0; i < seq_need; i++) v = (v << 6) | {26'b0, seq_bytes[i][5:0]};
        if ((v >= 32'hD800 && v <= 32'hDFFF) || v > 32'h10FFFF) begin
          emit(repl_cp, 1'b0, 1'b1);
        end else begin
          emit(v[CpW-1:0], 1'b0, 1'b0);
        end
        seq_need = 2'd0;
        seq_held = 2'd0;
      end
    end else begin
      flush_seq();
      if (b < 8'h80) begin
        emit({13'b0, b}, 1'b0, 1'b0);
      end else if (b <= 8'hBF || b >= 8'hF8) begin
        emit(win1252(b), 1'b1, 1'b0);
      end else begin
        seq_lead = b;
        seq_need = (b <= 8'hDF) ? 2'd1 : ((b <= 8'hEF) ? 2'd2 : 2'd3);
        seq_held = 2'd0;
      end
    end
    if (eot) flush_seq();
    for (i = 0; i < step_n; i++) begin
      cp_new = {step_cp[i], step_fb[i], step_rep[i], i == step_n - 1};
      cp_expected_q.insert(cp_expected_q.size(), cp_new);
    end
  endtask

  task automatic add_fixed(input logic [7:0] b, input logic eot);
    text_beat_t beat_new;
    beat_new = {b, eot};
    text_q.insert(text_q.size(), beat_new);
  endtask

  task automatic add_random(input int n);
    int         added;
    int         kind;
    int         len;
    int         i;
    logic [7:0] lead;
    added = 0;
    while (added < n) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        // lead byte with its full count of continuation bytes and random content
        len = $urandom_range(1, 4);
        case (len)
          1: lead = 8'($urandom_range(0, 8'h7F));
          2: lead = 8'($urandom_range(8'hC0, 8'hDF));
          3: lead = ($urandom_range(0, 3) == 0) ? 8'hED : 8'($urandom_range(8'hE0, 8'hEF));
          default: lead = 8'($urandom_range(8'hF0, 8'hF7));
        endcase
      end else if (kind < 9) begin
        len = 1;
        lead = 8'($urandom_range(0, 255));
      end else begin
        // sequence cut short, left to whatever follows
        lead = 8'($urandom_range(8'hC0, 8'hF7));
        len = (lead <= 8'hDF) ? 1 : ((lead <= 8'hEF) ? $urandom_range(1, 2)
                                                    : $urandom_range(1, 3));
      end
      add_fixed(lead, $urandom_range(0, 19) == 0);
      for (i = 1; i < len; i++) begin
        add_fixed({2'b10, 6'($urandom)}, $urandom_range(0, 19) == 0);
      end
      added += len;
    end
    add_fixed(8'($urandom_range(0, 8'h7F)), 1'b1);
  endtask

  task automatic wait_idle;
    @(negedge clk_i);
    while (text_q.size() != 0 || push || cp_expected_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_repl(input logic [CpW-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    repl_cp = v;
  endtask

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // sender
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        beat_now = text_q.pop_front();
        decode_byte(beat_now.data, beat_now.eot);
        beats_accepted <= beats_accepted + 1;
        if (burst_left > 0) burst_left--;
      end
      if (!(push && full)) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (text_q.size() != 0) begin
          push          <= 1'b1;
          byte_in_i     <= text_q[0].data;
          end_of_text_i <= text_q[0].eot;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        cp_got = {code_point_o, from_fallback_o, replaced_o, last_of_run_o};
        if (cp_expected_q.size() == 0) begin
          $display("%0t: expected no beat, got cp=%h fb=%b rep=%b last=%b", $time,
                   code_point_o, from_fallback_o, replaced_o, last_of_run_o);
          mismatches++;
        end else begin
          cp_want = cp_expected_q.pop_front();
          if (cp_got !== cp_want) begin
            $display("%0t: expected cp=%h fb=%b rep=%b last=%b, got cp=%h fb=%b rep=%b last=%b",
                     $time, cp_want.cp, cp_want.fb, cp_want.rep, cp_want.last,
                     cp_got.cp, cp_got.fb, cp_got.rep, cp_got.last);
            mismatches++;
          end
        end
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(8, 64);
        stall_mode = $urandom_range(0, 2);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (beats_accepted >= next_hold_at) begin
        // long hold so the decoder fills up and pushes back
        hold_left = 150;
        next_hold_at += 100;
        pop <= 1'b0;
      end else if (stall_mode == 0) begin
        pop <= 1'b1;
      end else if (stall_mode == 1) begin
        pop <= ($urandom_range(0, 3) != 0);
      end else begin
        pop <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  initial begin
    seq_bytes[0] = 8'h00;
    seq_bytes[1] = 8'h00;
    seq_bytes[2] = 8'h00;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // ascii, lone continuations, never-lead bytes
    add_fixed(8'h00, 1'b0); add_fixed(8'h7F, 1'b0); add_fixed(8'h80, 1'b0);
    add_fixed(8'h9F, 1'b0); add_fixed(8'hF8, 1'b0); add_fixed(8'hFF, 1'b0);
    // two, three and four byte forms
    add_fixed(8'hC3, 1'b0); add_fixed(8'hA9, 1'b0);
    add_fixed(8'hE2, 1'b0); add_fixed(8'h82, 1'b0); add_fixed(8'hAC, 1'b0);
    add_fixed(8'hF0, 1'b0); add_fixed(8'h9F, 1'b0); add_fixed(8'h98, 1'b0);
    add_fixed(8'h80, 1'b0);
    // surrogate and out of range
    add_fixed(8'hED, 1'b0); add_fixed(8'hA0, 1'b0); add_fixed(8'h80, 1'b0);
    add_fixed(8'hF7, 1'b0); add_fixed(8'hBF, 1'b0); add_fixed(8'hBF, 1'b0);
    add_fixed(8'hBF, 1'b0);
    // broken with two held, then truncated by end of text
    add_fixed(8'hF0, 1'b0); add_fixed(8'h9F, 1'b0); add_fixed(8'h98, 1'b0);
    add_fixed(8'hFF, 1'b0); add_fixed(8'hE2, 1'b1);
    add_random(52);
    wait_idle();

    write_repl(21'h000000);
    add_random(45);
    wait_idle();

    write_repl(21'h1FFFFF);
    add_random(45);
    wait_idle();

    write_repl(21'h10FFFF);
    add_random(45);
    wait_idle();

    write_repl(CpW'($urandom_range(0, 21'h1FFFFF)));
    add_random(48);
    wait_idle();

    if (mismatches == 0 && cp_expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
